/* design/rsame_pkg.sv */
// shared types and constants for the modular exponentiation core
package rsame_pkg;
  localparam int WordBits = 64;
  localparam int CntBits = 7;
  localparam logic [WordBits-1:0] ResetModulus = 64'd2;
  localparam logic [WordBits-1:0] ResetPublicExp = 64'd65537;
  localparam logic [WordBits-1:0] ResetPrivateExp = 64'd0;

  localparam logic [1:0] RegModulus = 2'd0;
  localparam logic [1:0] RegPublicExp = 2'd1;
  localparam logic [1:0] RegPrivateExp = 2'd2;

  localparam logic OpEncrypt = 1'b0;

  typedef struct packed {
    logic op;
    logic [WordBits-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] value_out;
    logic too_large;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_MUL_START,
    CMD_MUL_STEP,
    CMD_MUL_DONE,
    CMD_SHIFT
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic zero_mod;
    logic exp_zero;
    logic exp_bit;
    logic reduce_done;
    logic mul_last;
  } dp_status_t;
endpackage

/* design/rsame_datapath.sv */
// operand registers, restoring reduction and bit-serial modular multiplier
module rsame_datapath import rsame_pkg::*; (
  input  logic clk,
  input  dp_cmd_t cmd,
  input  logic mul_sq,
  input  in_item_t item,
  input  logic [WordBits-1:0] modulus,
  input  logic [WordBits-1:0] public_exponent,
  input  logic [WordBits-1:0] private_exponent,
  output dp_status_t status,
  output logic [WordBits-1:0] acc
);
  logic [WordBits-1:0] sq, ex, m, r, a, b, rem;
  logic [CntBits-1:0] cnt;
  logic [WordBits:0] dbl, dbl_red, sum, sum_red, rem2;

  // one shift-and-add step: r = 2r (+ b) mod m, all with a carry bit
  always_comb begin
    dbl = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = dbl_red + {1'b0, b};
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    rem2 = {rem, sq[WordBits-1-cnt[5:0]]};
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        m <= modulus;
        ex <= (item.op == OpEncrypt) ? public_exponent : private_exponent;
        sq <= item.value_in;
        acc <= (modulus == 64'd1) ? '0 : 64'd1;
        rem <= '0;
        cnt <= '0;
      end
      CMD_REDUCE: begin
        // restoring reduction of the base, one bit a cycle
        if (rem2 >= {1'b0, m}) rem <= WordBits'(rem2 - {1'b0, m});
        else rem <= rem2[WordBits-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CntBits'(WordBits - 1)) begin
          sq <= (rem2 >= {1'b0, m}) ? WordBits'(rem2 - {1'b0, m})
                                    : rem2[WordBits-1:0];
        end
      end
      CMD_MUL_START: begin
        r <= '0;
        a <= mul_sq ? sq : acc;
        b <= sq;
        cnt <= '0;
      end
      CMD_MUL_STEP: begin
        r <= a[WordBits-1] ? sum_red[WordBits-1:0] : dbl_red[WordBits-1:0];
        a <= {a[WordBits-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      CMD_MUL_DONE: begin
        if (mul_sq) sq <= r;
        else acc <= r;
      end
      CMD_SHIFT: ex <= ex >> 1;
      default: ;
    endcase
  end

  always_comb begin
    status.reject = (item.op == OpEncrypt) && (item.value_in >= modulus);
    status.zero_mod = (modulus == '0);
    status.exp_zero = (ex == '0);
    status.exp_bit = ex[0];
    status.reduce_done = (cnt == CntBits'(WordBits - 1));
    status.mul_last = (cnt == CntBits'(WordBits - 1));
  end
endmodule

/* design/rsame_ctrl.sv */
// sequencer for square-and-multiply and result handshake
module rsame_ctrl import rsame_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  dp_status_t status,
  output dp_cmd_t cmd,
  output logic mul_sq,
  output logic result_zero,
  output logic result_flag
);
  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_CHECK, S_MUL, S_MDONE, S_SQSTART, S_SQ, S_SQDONE, S_SHIFT, S_OUT
  } state_t;
  state_t state;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign mul_sq = (state == S_SQSTART) || (state == S_SQ) || (state == S_SQDONE);

  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      S_IDLE: if (in_valid && !out_valid) cmd = CMD_LOAD;
      S_REDUCE: cmd = CMD_REDUCE;
      S_CHECK: if (!status.exp_zero && status.exp_bit) cmd = CMD_MUL_START;
      S_MUL, S_SQ: cmd = CMD_MUL_STEP;
      S_MDONE, S_SQDONE: cmd = CMD_MUL_DONE;
      S_SQSTART: cmd = CMD_MUL_START;
      S_SHIFT: cmd = CMD_SHIFT;
      S_OUT: cmd = CMD_NONE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      result_zero <= 1'b0;
      result_flag <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !out_valid) begin
          result_flag <= status.reject;
          result_zero <= status.reject || status.zero_mod;
          state <= (status.reject || status.zero_mod) ? S_OUT : S_REDUCE;
        end
        S_REDUCE: if (status.reduce_done) state <= S_CHECK;
        S_CHECK: begin
          if (status.exp_zero) state <= S_OUT;
          else state <= status.exp_bit ? S_MUL : S_SQSTART;
        end
        S_MUL: if (status.mul_last) state <= S_MDONE;
        // product done; now the square
        S_MDONE: state <= S_SQSTART;
        S_SQSTART: state <= S_SQ;
        S_SQ: if (status.mul_last) state <= S_SQDONE;
        S_SQDONE: state <= S_SHIFT;
        S_SHIFT: state <= S_CHECK;
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/rsa_modular_exponentiation_core.sv */
// top level of the modular exponentiation core
// Usage:
//   configure modulus, public_exponent and private_exponent through cfg_we,
//   cfg_index and cfg_data while the core is idle.
//   an input transaction carries op (0 encrypt, 1 decrypt) and value_in;
//   exactly one output transaction follows with value_out and too_large.
// Sequence: the base is first reduced mod the modulus, then per exponent bit up
//   to the top set bit a square follows, with a product before it when the bit
//   is one; both use the bit-serial shift-and-add modular multiplier. A
//   rejected encrypt or a zero modulus goes straight to the output.
// Throughput: one transaction at a time; in_stall is high while busy or
//   while a result waits.
// Reset: rst (synchronous) restores modulus 2, public exponent 65537,
//   private exponent 0 and empties the core.
// Stall: the result is held in the output register while out_stall is high.
module rsa_modular_exponentiation_core import rsame_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [WordBits-1:0] cfg_data
);
  logic [WordBits-1:0] modulus, public_exponent, private_exponent, acc;
  dp_status_t status;
  dp_cmd_t cmd;
  logic mul_sq, result_zero, result_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ResetModulus;
      public_exponent <= ResetPublicExp;
      private_exponent <= ResetPrivateExp;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegModulus: modulus <= cfg_data;
        RegPublicExp: public_exponent <= cfg_data;
        RegPrivateExp: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  rsame_datapath u_dp (
    .clk, .cmd, .mul_sq, .item(in_data), .modulus, .public_exponent,
    .private_exponent, .status, .acc
  );

  rsame_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd,
    .mul_sq, .result_zero, .result_flag
  );

  assign out_data.value_out = result_zero ? '0 : acc;
  assign out_data.too_large = result_flag;
endmodule
